// ===== rtl/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants for the three-wire serial register master
// Beat layouts for the tick and result channels, phase codes, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

  // Field and counter widths
  localparam int unsigned PHASE_W       = 16;
  localparam int unsigned READ_W        = 32;
  localparam int unsigned CNT_W         = 6;
  localparam int unsigned MAX_READ_BITS = 32;
  localparam int unsigned BYTE_BITS     = 8;
  localparam logic [7:0]  MSB_MASK      = 8'h80;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_EN   = 1'b1;

  // Request codes carried with each tick
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_DATA  = 2'd3
  } tws_cmd_e;

  // Bit sequencer phases, one-hot
  typedef enum logic [7:0] {
    PH_IDLE       = 8'b0000_0001,
    PH_BIT_LOW    = 8'b0000_0010,
    PH_BIT_HIGH   = 8'b0000_0100,
    PH_DUMMY_HIGH = 8'b0000_1000,
    PH_DUMMY_LOW  = 8'b0001_0000,
    PH_READ_LOW   = 8'b0010_0000,
    PH_READ_HIGH  = 8'b0100_0000,
    PH_WAIT_DATA  = 8'b1000_0000
  } tws_phase_e;

  // One tick beat
  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       byte_value;
    logic [CNT_W-1:0] read_bits;
    logic [7:0]       dummy_clocks;
    logic             last;
    logic             sda_in;
  } tws_in_t;

  // One result beat
  typedef struct packed {
    logic              sck;
    logic              sda_out;
    logic              sda_drive;
    logic              dc_level;
    logic              cs_n;
    logic              busy_res;
    logic [READ_W-1:0] read_data;
    logic              read_done;
    logic              rejected;
  } tws_out_t;

endpackage

`default_nettype wire

// ===== rtl/three_wire_spi_register_master.sv =====
// ----------------------------------------------------------------------------
// three_wire_spi_register_master: bit sequencer for a shared-data-line link
// Each tick beat advances the half-bit phase timer and may start a read or
// write transaction or hand over the next write byte; one result beat per tick.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              beat
//  -------   ---------  ---------------------  ---------------------------
//  tick      in         in_valid_i/in_stall_o  tws_in_t  (request + sda)
//  result    out        out_valid_o/out_stall_i tws_out_t (pin levels, data)
//  config    in         cfg_valid_i/cfg_ready_o index + 16-bit write data
//
//  One tick beat is taken every clock unless the tick channel is stalled; its result appears in the output
//  register on the following cycle. The whole tick is one pass of logic
//  from the sequencer registers into the result register.
//  Reset puts the sequencer in idle with chip select high and the line released.
//  A stalled result holds the tick channel only while the result register is
//  full and not being taken; config writes are always ready.
//
`default_nettype none

module three_wire_spi_register_master (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire tws_pkg::tws_in_t                in_data_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      tws_pkg::tws_out_t               out_data_o,
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [tws_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [tws_pkg::PHASE_W-1:0]     cfg_data_i
);
  import tws_pkg::*;

  // Configuration
  logic [PHASE_W-1:0] phase_ticks_q;
  logic               select_en_q;

  // Sequencer state
  tws_phase_e         phase_q, phase_d;
  logic [PHASE_W-1:0] wait_q, wait_d;
  logic [7:0]         shift_q, shift_d;
  logic [CNT_W-1:0]   bit_q, bit_d;
  logic [7:0]         dummy_q, dummy_d;
  logic [READ_W-1:0]  read_q, read_d;
  logic               read_mode_q, read_mode_d;
  logic               release_q, release_d;
  logic               select_q, select_d;
  logic               data_q, data_d;
  logic               dc_q, dc_d;
  logic [CNT_W-1:0]   target_q, target_d;

  // Result register
  logic               out_valid_q;
  tws_out_t           out_q;
  tws_out_t           res;

  logic               accept;
  logic [PHASE_W-1:0] ticks;
  logic               active_pre;
  logic               active_post;
  logic               body;
  logic               finish;
  logic               drive;
  logic [CNT_W-1:0]   bit_next;
  logic [CNT_W-1:0]   nbits_sat;
  tws_cmd_e           cmd;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ticks     = (phase_ticks_q == '0) ? PHASE_W'(1) : phase_ticks_q;
  assign cmd       = tws_cmd_e'(in_data_i.cmd);
  assign nbits_sat = (in_data_i.read_bits > CNT_W'(MAX_READ_BITS)) ?
                     CNT_W'(MAX_READ_BITS) : in_data_i.read_bits;

  // One tick: phase advance, request handling, timer, pin levels
  always_comb begin
    phase_d     = phase_q;
    wait_d      = wait_q;
    shift_d     = shift_q;
    bit_d       = bit_q;
    dummy_d     = dummy_q;
    read_d      = read_q;
    read_mode_d = read_mode_q;
    release_d   = release_q;
    select_d    = select_q;
    data_d      = data_q;
    dc_d        = dc_q;
    target_d    = target_q;
    body        = 1'b0;
    finish      = 1'b0;
    bit_next    = bit_q + CNT_W'(1);
    res         = '0;

    // phase change once the half-bit timer has run out
    active_pre = (phase_q != PH_IDLE) && (phase_q != PH_WAIT_DATA);
    if (active_pre && (wait_q >= ticks)) begin
      case (phase_q)
        PH_BIT_LOW: begin
          phase_d = PH_BIT_HIGH;
          wait_d  = '0;
        end
        PH_BIT_HIGH: begin
          bit_d   = bit_next;
          shift_d = {shift_q[6:0], 1'b0};
          if (bit_next < CNT_W'(BYTE_BITS)) begin
            data_d  = (shift_d & MSB_MASK) != '0;
            phase_d = PH_BIT_LOW;
            wait_d  = '0;
          end else if (read_mode_q) begin
            dc_d = 1'b1;
            body = 1'b1;
          end else if (release_q) begin
            phase_d  = PH_IDLE;
            wait_d   = '0;
            select_d = 1'b0;
          end else begin
            phase_d = PH_WAIT_DATA;
            wait_d  = '0;
          end
        end
        PH_DUMMY_HIGH: begin
          phase_d = PH_DUMMY_LOW;
          wait_d  = '0;
        end
        PH_DUMMY_LOW: begin
          dummy_d = dummy_q - 8'd1;
          body    = 1'b1;
        end
        PH_READ_LOW: begin
          read_d  = {read_q[READ_W-2:0], in_data_i.sda_in};
          phase_d = PH_READ_HIGH;
          wait_d  = '0;
        end
        PH_READ_HIGH: begin
          bit_d = bit_next;
          if (bit_next < target_q) begin
            phase_d = PH_READ_LOW;
            wait_d  = '0;
          end else begin
            finish = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // after the command byte or a dummy pulse: more dummies, read bits or end
      if (body) begin
        if (dummy_d != '0) begin
          phase_d = PH_DUMMY_HIGH;
          wait_d  = '0;
        end else if (target_q != '0) begin
          bit_d   = '0;
          phase_d = PH_READ_LOW;
          wait_d  = '0;
        end else begin
          finish = 1'b1;
        end
      end

      if (finish) begin
        phase_d  = PH_IDLE;
        wait_d   = '0;
        select_d = 1'b0;
      end
    end

    // requests, seen after the phase change
    case (cmd)
      CMD_READ, CMD_WRITE: begin
        if (phase_d == PH_IDLE) begin
          select_d    = select_en_q;
          read_mode_d = (cmd == CMD_READ);
          if (cmd == CMD_READ) begin
            release_d = 1'b1;
            target_d  = nbits_sat;
            dummy_d   = in_data_i.dummy_clocks;
            read_d    = '0;
          end else begin
            release_d = in_data_i.last;
          end
          shift_d = in_data_i.byte_value;
          bit_d   = '0;
          dc_d    = 1'b0;
          data_d  = (in_data_i.byte_value & MSB_MASK) != '0;
          phase_d = PH_BIT_LOW;
          wait_d  = '0;
        end else begin
          res.rejected = 1'b1;
        end
      end
      CMD_DATA: begin
        if (phase_d == PH_WAIT_DATA) begin
          release_d = in_data_i.last;
          shift_d   = in_data_i.byte_value;
          bit_d     = '0;
          dc_d      = 1'b1;
          data_d    = (in_data_i.byte_value & MSB_MASK) != '0;
          phase_d   = PH_BIT_LOW;
          wait_d    = '0;
        end else begin
          res.rejected = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // half-bit timer
    active_post = (phase_d != PH_IDLE) && (phase_d != PH_WAIT_DATA);
    if (active_post && (wait_d < ticks)) begin
      wait_d = wait_d + PHASE_W'(1);
    end

    // pin levels for this tick
    drive = (phase_d == PH_BIT_LOW) || (phase_d == PH_BIT_HIGH) ||
            (phase_d == PH_WAIT_DATA);
    res.sck       = (phase_d == PH_BIT_HIGH) || (phase_d == PH_DUMMY_HIGH) ||
                    (phase_d == PH_READ_HIGH);
    res.sda_out   = drive & data_d;
    res.sda_drive = drive;
    res.dc_level  = dc_d;
    res.cs_n      = ~select_d;
    res.busy_res  = active_post;
    res.read_data = read_d;
    res.read_done = finish;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PHASE_W'(1);
      select_en_q   <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PHASE_TICKS: phase_ticks_q <= cfg_data_i;
        CFG_SELECT_EN:   select_en_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state, updated once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      wait_q      <= '0;
      shift_q     <= '0;
      bit_q       <= '0;
      dummy_q     <= '0;
      read_q      <= '0;
      read_mode_q <= 1'b0;
      release_q   <= 1'b0;
      select_q    <= 1'b0;
      data_q      <= 1'b0;
      dc_q        <= 1'b1;
      target_q    <= '0;
    end else if (accept) begin
      phase_q     <= phase_d;
      wait_q      <= wait_d;
      shift_q     <= shift_d;
      bit_q       <= bit_d;
      dummy_q     <= dummy_d;
      read_q      <= read_d;
      read_mode_q <= read_mode_d;
      release_q   <= release_d;
      select_q    <= select_d;
      data_q      <= data_d;
      dc_q        <= dc_d;
      target_q    <= target_d;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  // Checks
  a_idle_deselected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> !select_q)
    else $error("chip select held while sequencer idle");

  // a new start may follow on the tick a read ends
  a_done_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.read_done && !out_q.busy_res) |-> out_q.cs_n)
    else $error("read finished with chip select still low");

  a_tick_not_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.cmd == CMD_TICK)) |=> !out_q.rejected)
    else $error("plain tick flagged as rejected");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("tick channel stalled with empty result register");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: regression for three_wire_spi_register_master
// Drives one tick beat per item with read, write and data requests. A
// behavioural copy of the bit sequencer predicts every result beat, and each
// result beat is checked field by field. Register settings are changed
// between bursts, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tws_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1250;
  localparam int unsigned GAP_MAX      = 12;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned CFG_SETTLE   = 2;
  localparam int unsigned REPORT_MAX   = 10;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // DUT connections
  logic                 tick_valid = 1'b0;
  logic                 tick_stall;
  tws_in_t              tick_beat  = '0;
  logic                 res_valid;
  logic                 res_stall  = 1'b0;
  tws_out_t             res_beat;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_PHASE_TICKS;
  logic [PHASE_W-1:0]   cfg_data   = '0;

  three_wire_spi_register_master uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (tick_valid),
    .in_stall_o  (tick_stall),
    .in_data_i   (tick_beat),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Register copies
  logic [PHASE_W-1:0] set_half_ticks = 16'd1;
  logic               set_select_en  = 1'b1;

  // Sequencer copy, reset values
  tws_phase_e         seq_phase   = PH_IDLE;
  logic [PHASE_W-1:0] seq_wait    = '0;
  logic [7:0]         seq_shift   = '0;
  logic [CNT_W-1:0]   seq_bits    = '0;
  logic [7:0]         seq_dummy   = '0;
  logic [READ_W-1:0]  seq_rx      = '0;
  logic               seq_read    = 1'b0;
  logic               seq_release = 1'b0;
  logic               seq_select  = 1'b0;
  logic               seq_sck     = 1'b0;
  logic               seq_sda     = 1'b0;
  logic               seq_dc      = 1'b1;
  logic [CNT_W-1:0]   seq_target  = '0;
  logic               seq_done    = 1'b0;

  // Pin levels still owed by the block, oldest first
  tws_out_t expected_pins_q[$];

  // Run control and tallies
  int unsigned send_gap_max = GAP_MAX;
  int unsigned sink_gap_max = GAP_MAX;
  int unsigned next_gap     = 0;
  bit          valid_held   = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned ticks_sent   = 0;
  int unsigned checked      = 0;
  int unsigned fail_count   = 0;
  int unsigned reads_ended  = 0;
  int unsigned drops        = 0;
  int unsigned reg_writes   = 0;

  // --------------------------------------------------------------------------
  // Bit sequencer prediction
  // --------------------------------------------------------------------------
  function automatic void go_phase(tws_phase_e p);
    seq_phase = p;
    seq_wait  = '0;
    seq_sck   = (p inside {PH_BIT_HIGH, PH_DUMMY_HIGH, PH_READ_HIGH});
  endfunction

  function automatic void end_read();
    go_phase(PH_IDLE);
    seq_select = 1'b0;
    seq_done   = 1'b1;
  endfunction

  // After the command byte or a dummy pulse: more dummies, read bits, or done
  function automatic void next_read_step();
    if (seq_dummy != 0) begin
      go_phase(PH_DUMMY_HIGH);
    end else if (seq_target != 0) begin
      seq_bits = '0;
      go_phase(PH_READ_LOW);
    end else begin
      end_read();
    end
  endfunction

  function automatic void load_tx_byte(logic [7:0] value, logic dc);
    seq_shift = value;
    seq_bits  = '0;
    seq_dc    = dc;
    seq_sda   = (value & MSB_MASK) != 0;
    go_phase(PH_BIT_LOW);
  endfunction

  // Half-phase timer expired: move to the next half
  function automatic void advance_phase(logic sda);
    case (seq_phase)
      PH_BIT_LOW: go_phase(PH_BIT_HIGH);
      PH_BIT_HIGH: begin
        seq_bits  = seq_bits + 1'b1;
        seq_shift = seq_shift << 1;
        if (seq_bits < CNT_W'(BYTE_BITS)) begin
          seq_sda = (seq_shift & MSB_MASK) != 0;
          go_phase(PH_BIT_LOW);
        end else if (seq_read) begin
          seq_dc = 1'b1;
          next_read_step();
        end else if (seq_release) begin
          go_phase(PH_IDLE);
          seq_select = 1'b0;
        end else begin
          go_phase(PH_WAIT_DATA);
        end
      end
      PH_DUMMY_HIGH: go_phase(PH_DUMMY_LOW);
      PH_DUMMY_LOW: begin
        seq_dummy = seq_dummy - 1'b1;
        next_read_step();
      end
      PH_READ_LOW: begin
        seq_rx = {seq_rx[READ_W-2:0], sda};
        go_phase(PH_READ_HIGH);
      end
      PH_READ_HIGH: begin
        seq_bits = seq_bits + 1'b1;
        if (seq_bits < seq_target) go_phase(PH_READ_LOW);
        else end_read();
      end
      default: ;
    endcase
  endfunction

  // One tick: timer, then request, then pin levels
  function automatic tws_out_t sequencer_tick(tws_in_t t);
    tws_out_t           r;
    logic [PHASE_W-1:0] ticks;
    logic               busy;
    logic               drive;
    logic               rej;
    ticks    = (set_half_ticks == 0) ? PHASE_W'(1) : set_half_ticks;
    rej      = 1'b0;
    seq_done = 1'b0;
    busy     = (seq_phase != PH_IDLE) && (seq_phase != PH_WAIT_DATA);
    if (busy && seq_wait >= ticks) advance_phase(t.sda_in);

    case (t.cmd)
      CMD_READ, CMD_WRITE: begin
        if (seq_phase == PH_IDLE) begin
          seq_select = set_select_en;
          seq_read   = (t.cmd == CMD_READ);
          if (seq_read) begin
            seq_release = 1'b1;
            seq_target  = (t.read_bits > MAX_READ_BITS) ? CNT_W'(MAX_READ_BITS) : t.read_bits;
            seq_dummy   = t.dummy_clocks;
            seq_rx      = '0;
          end else begin
            seq_release = t.last;
          end
          load_tx_byte(t.byte_value, 1'b0);
        end else begin
          rej = 1'b1;
        end
      end
      CMD_DATA: begin
        if (seq_phase == PH_WAIT_DATA) begin
          seq_release = t.last;
          load_tx_byte(t.byte_value, 1'b1);
        end else begin
          rej = 1'b1;
        end
      end
      default: ;
    endcase

    busy = (seq_phase != PH_IDLE) && (seq_phase != PH_WAIT_DATA);
    if (busy && seq_wait < ticks) seq_wait = seq_wait + 1'b1;
    drive = (seq_phase inside {PH_BIT_LOW, PH_BIT_HIGH, PH_WAIT_DATA});

    r.sck       = seq_sck;
    r.sda_out   = drive & seq_sda;
    r.sda_drive = drive;
    r.dc_level  = seq_dc;
    r.cs_n      = !seq_select;
    r.busy_res  = busy;
    r.read_data = seq_rx;
    r.read_done = seq_done;
    r.rejected  = rej;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic tws_in_t random_beat(tws_cmd_e c);
    tws_in_t b;
    b.cmd          = c;
    b.byte_value   = 8'($urandom);
    b.read_bits    = CNT_W'($urandom);
    b.dummy_clocks = 8'($urandom);
    b.last         = 1'($urandom);
    b.sda_in       = 1'($urandom);
    return b;
  endfunction

  // Offer one tick beat, predict its pins once it is taken
  task automatic send_tick(tws_in_t t);
    repeat (next_gap) @(posedge clk);
    tick_valid <= 1'b1;
    tick_beat  <= t;
    do @(posedge clk); while (tick_stall);
    expected_pins_q.push_back(sequencer_tick(t));
    ticks_sent++;
    next_gap = $urandom_range(0, send_gap_max);
    if (next_gap != 0) begin
      tick_valid <= 1'b0;
      valid_held = 1'b0;
    end else begin
      valid_held = 1'b1;
    end
  endtask

  task automatic idle_input();
    if (valid_held) begin
      tick_valid <= 1'b0;
      valid_held = 1'b0;
    end
  endtask

  // Register write, only once every owed result beat has arrived
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [PHASE_W-1:0] value);
    idle_input();
    while (expected_pins_q.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_PHASE_TICKS) set_half_ticks = value;
    else set_select_en = value[0];
    reg_writes++;
  endtask

  // Plain ticks until the sequencer rests; noisy adds stray requests
  task automatic tick_until_rest(bit noisy);
    tws_in_t b;
    while (seq_phase != PH_IDLE && seq_phase != PH_WAIT_DATA) begin
      b = random_beat(CMD_TICK);
      if (noisy && $urandom_range(0, 15) == 0) b.cmd = 2'($urandom_range(1, 3));
      send_tick(b);
    end
  endtask

  // Run to idle, feeding data bytes to any write that waits for one
  task automatic complete_transaction(int bytes_left, bit noisy);
    tws_in_t b;
    tick_until_rest(noisy);
    while (seq_phase == PH_WAIT_DATA) begin
      b      = random_beat(CMD_DATA);
      b.last = (bytes_left <= 1);
      bytes_left--;
      send_tick(b);
      tick_until_rest(noisy);
    end
  endtask

  task automatic start_read(logic [7:0] value, logic [CNT_W-1:0] nbits, logic [7:0] ndummy,
                            bit noisy);
    tws_in_t b;
    b              = random_beat(CMD_READ);
    b.byte_value   = value;
    b.read_bits    = nbits;
    b.dummy_clocks = ndummy;
    send_tick(b);
    complete_transaction(0, noisy);
  endtask

  task automatic start_write(logic [7:0] value, int nbytes, bit noisy);
    tws_in_t b;
    b            = random_beat(CMD_WRITE);
    b.byte_value = value;
    b.last       = (nbytes == 0);
    send_tick(b);
    complete_transaction(nbytes, noisy);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Idle pins after reset; a data byte with no open write is dropped
  task automatic test_idle_requests();
    tws_in_t b;
    send_tick(random_beat(CMD_DATA));
    b = random_beat(CMD_TICK);
    b.sda_in = 1'b0;
    send_tick(b);
    b.sda_in = 1'b1;
    send_tick(b);
  endtask

  // Write: busy rejections, start during a data wait, two data bytes, lone command
  task automatic test_write_path();
    tws_in_t b;
    send_gap_max = 0;
    b            = random_beat(CMD_WRITE);
    b.byte_value = 8'hA5;
    b.last       = 1'b0;
    send_tick(b);
    send_tick(random_beat(CMD_READ));
    send_tick(random_beat(CMD_DATA));
    tick_until_rest(1'b0);
    send_tick(random_beat(CMD_TICK));
    send_tick(random_beat(CMD_WRITE));
    b            = random_beat(CMD_DATA);
    b.byte_value = 8'hFF;
    b.last       = 1'b0;
    send_tick(b);
    tick_until_rest(1'b0);
    b.byte_value = 8'h00;
    b.last       = 1'b1;
    send_tick(b);
    tick_until_rest(1'b0);
    send_gap_max = GAP_MAX;
    start_write(8'h3C, 0, 1'b0);
  endtask

  // Read: saturated bit count, zero bits, full width, longest dummy run
  task automatic test_read_path();
    start_read(8'h0B, 6'd63, 8'd0, 1'b0);
    start_read(8'h5A, 6'd0, 8'd2, 1'b0);
    start_read(8'hFF, 6'd32, 8'd255, 1'b0);
    start_read(8'h00, 6'd1, 8'd1, 1'b0);
  endtask

  // Register extremes, select off, select change inside a write
  task automatic test_register_settings();
    tws_in_t b;
    write_register(CFG_PHASE_TICKS, 16'd0);
    start_write(8'h96, 1, 1'b0);
    write_register(CFG_SELECT_EN, 16'd0);
    start_read(8'h69, 6'd8, 8'd1, 1'b0);
    write_register(CFG_SELECT_EN, 16'd1);
    b      = random_beat(CMD_WRITE);
    b.last = 1'b0;
    send_tick(b);
    tick_until_rest(1'b0);
    write_register(CFG_SELECT_EN, 16'd0);
    complete_transaction(1, 1'b0);
    start_write(8'h5A, 1, 1'b0);
    // longest half-phase: only the timer moves
    write_register(CFG_PHASE_TICKS, 16'hFFFF);
    b      = random_beat(CMD_WRITE);
    b.last = 1'b0;
    send_tick(b);
    repeat (40) send_tick(random_beat(CMD_TICK));
    write_register(CFG_PHASE_TICKS, 16'd3);
    complete_transaction(2, 1'b0);
    write_register(CFG_PHASE_TICKS, 16'd1);
    write_register(CFG_SELECT_EN, 16'd1);
  endtask

  // Result side holds off while ticks keep coming, so the input backs up
  task automatic test_result_hold();
    send_gap_max = 0;
    sink_gap_max = 0;
    hold_off_req = 1'b1;
    start_read(8'hC3, 6'd16, 8'd2, 1'b0);
    send_gap_max = GAP_MAX;
    sink_gap_max = GAP_MAX;
  endtask

  // Mostly whole transactions with random content, some stray beats,
  // until the whole run reaches its tick count
  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned n_tx;
    int unsigned pick;
    int unsigned nbits;
    int unsigned ndummy;
    goal = ITEM_TARGET;
    n_tx = 0;
    while (ticks_sent < goal) begin
      if (n_tx % 8 == 0) begin
        send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
        sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      end
      if ($urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, 19);
        write_register(CFG_PHASE_TICKS,
                       (pick == 0) ? 16'd0 : (pick < 4) ? 16'd2 : (pick < 6) ? 16'd3 : 16'd1);
        write_register(CFG_SELECT_EN, ($urandom_range(0, 3) != 0) ? 16'd1 : 16'd0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        nbits = $urandom_range(0, 19);
        nbits = (nbits == 0) ? $urandom_range(33, 63) : (nbits == 1) ? 32 : $urandom_range(0, 10);
        ndummy = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 255) : $urandom_range(0, 4);
        start_read(8'($urandom), CNT_W'(nbits), 8'(ndummy), 1'b1);
      end else if (pick < 85) begin
        start_write(8'($urandom), $urandom_range(0, 4), 1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) send_tick(random_beat(tws_cmd_e'($urandom_range(0, 3))));
        complete_transaction($urandom_range(1, 4), 1'b1);
      end
      n_tx++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall per beat, plus the long hold on request
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
      end else if (res_valid && !res_stall) begin
        gap = $urandom_range(0, sink_gap_max);
        if (gap != 0) begin
          res_stall <= 1'b1;
          repeat (gap) @(posedge clk);
          res_stall <= 1'b0;
        end
      end
    end
  end

  // Compare each taken result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    tws_out_t want;
    string    diffs;
    if (rst_n && res_valid && !res_stall) begin
      checked++;
      if (expected_pins_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("result beat %0d arrived with nothing owed: got %h", checked, res_beat);
      end else begin
        want        = expected_pins_q.pop_front();
        reads_ended += want.read_done;
        drops       += want.rejected;
        diffs       = "";
        if (res_beat.sck       !== want.sck)       diffs = {diffs, " sck"};
        if (res_beat.sda_out   !== want.sda_out)   diffs = {diffs, " sda_out"};
        if (res_beat.sda_drive !== want.sda_drive) diffs = {diffs, " sda_drive"};
        if (res_beat.dc_level  !== want.dc_level)  diffs = {diffs, " dc_level"};
        if (res_beat.cs_n      !== want.cs_n)      diffs = {diffs, " cs_n"};
        if (res_beat.busy_res  !== want.busy_res)  diffs = {diffs, " busy_res"};
        if (res_beat.read_data !== want.read_data) diffs = {diffs, " read_data"};
        if (res_beat.read_done !== want.read_done) diffs = {diffs, " read_done"};
        if (res_beat.rejected  !== want.rejected)  diffs = {diffs, " rejected"};
        if (diffs != "") begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("result beat %0d differs in%s: expected %h (read_data %h), got %h (read_data %h)",
                     checked, diffs, want, want.read_data, res_beat, res_beat.read_data);
        end
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long
  initial begin : watchdog
    int unsigned stale;
    stale = 0;
    while (stale < STALL_LIMIT) begin
      @(posedge clk);
      if ((tick_valid && !tick_stall) || (res_valid && !res_stall)) stale = 0;
      else stale++;
    end
    $display("timeout: no beat moved for %0d cycles, %0d results owed",
             STALL_LIMIT, expected_pins_q.size());
    $display("three_wire_spi_register_master regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_requests();
    test_write_path();
    test_read_path();
    test_register_settings();
    test_result_hold();
    test_random_traffic();

    idle_input();
    while (expected_pins_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Run covered %0d tick beats, %0d finished reads, %0d dropped requests, %0d register writes.",
             ticks_sent, reads_ended, drops, reg_writes);
    $display("%0d result beats checked, %0d mismatching.", checked, fail_count);
    if (fail_count == 0) begin
      $display("three_wire_spi_register_master regression: pass");
    end else begin
      $display("three_wire_spi_register_master regression: fail");
    end
    $finish;
  end

endmodule
